// File: hw/rtl/pdd_pkg.sv
// Shared types and constants for the peak-detect downsampler.
package pdd_pkg;

  localparam int TIME_W       = 32;
  localparam int LIMIT_W      = 13;
  localparam int BUCKET_SHIFT = 2;  // four representatives per bucket
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FETCH  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WSTART = 2'd0,
    REG_WEND   = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIRECT,
    PH_BUCKET,
    PH_DRAINED
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_BUILD,
    S_BDIV,
    S_BRD,
    S_BCHK,
    S_BSLOT,
    S_EMIT,
    S_OUT
  } eng_state_t;

  // Head of the command queue as seen by the engine.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// File: hw/rtl/peak_detect_downsampler.sv
// Top level of the peak-detect downsampler: stream ports, queue and engine.
//
//  channel | direction | payload
//  in_     | slave     | tuser: command; tdata: sample_time, sample_value
//  out_    | master    | tdata: point_time, point_value, visible_count;
//          |           | tlast: last_point; tuser: no_point, overflow
//  cfg_    | slave     | cfg_addr register index, cfg_data value
//
// Load and clear are applied by the engine from its idle state; a fetch on a
// ready trace reads a point from the store. The first fetch after a change
// scans the record through the single store read port, then the first bucket.
// Each later bucket reads every sample it covers. A 4-word queue lets loads
// stream in while the engine is busy. Reset is synchronous; no clearing pass.
module peak_detect_downsampler import pdd_pkg::*; #(
  parameter int SAMPLE_DEPTH = 4096,
  parameter int VALUE_BITS   = 16,
  localparam int CW   = $clog2(SAMPLE_DEPTH + 1),
  localparam int INW  = ((TIME_W + VALUE_BITS + 7) / 8) * 8,
  localparam int OUTW = ((TIME_W + VALUE_BITS + CW + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [INW-1:0]  in_tdata,   // sample_time, sample_value
  input  logic [1:0]      in_tuser,   // command
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OUTW-1:0] out_tdata,  // point_time, point_value, visible_count
  output logic            out_tlast,
  output logic [1:0]      out_tuser,  // no_point, overflow
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_addr,
  input  logic [31:0]     cfg_data
);

  q_head_t               head;
  logic [TIME_W-1:0]     head_time;
  logic [VALUE_BITS-1:0] head_value;
  logic                  pop;
  logic [TIME_W-1:0]     res_time;
  logic [VALUE_BITS-1:0] res_value;
  logic [CW-1:0]         res_visible;
  logic                  res_last, res_none, res_ovf;

  assign cfg_ready = 1'b1;

  pdd_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_valid  (in_tvalid),
    .acc_ready  (in_tready),
    .acc_cmd    (cmd_t'(in_tuser)),
    .acc_time   (in_tdata[TIME_W-1:0]),
    .acc_value  (in_tdata[TIME_W+VALUE_BITS-1:TIME_W]),
    .head       (head),
    .head_time  (head_time),
    .head_value (head_value),
    .pop        (pop)
  );

  pdd_engine #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_time   (head_time),
    .head_value  (head_value),
    .pop         (pop),
    .cfg_we      (cfg_valid),
    .cfg_idx     (reg_idx_t'(cfg_addr)),
    .cfg_wdata   (cfg_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_time    (res_time),
    .res_value   (res_value),
    .res_visible (res_visible),
    .res_last    (res_last),
    .res_none    (res_none),
    .res_ovf     (res_ovf)
  );

  assign out_tdata = OUTW'({res_visible, res_value, res_time});
  assign out_tlast = res_last;
  assign out_tuser = {res_ovf, res_none};

`ifndef ASSERT_OFF
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[TIME_W+VALUE_BITS-1:0] == '0 && !out_tlast)
    else $error("empty word carries point data");

  a_vis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_visible <= CW'(SAMPLE_DEPTH))
    else $error("visible count above store depth");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule

// File: hw/rtl/pdd_front.sv
// Front end: accepts input words, drops no-op commands, queues the rest.
module pdd_front import pdd_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_valid,
  output logic                  acc_ready,
  input  cmd_t                  acc_cmd,
  input  logic [TIME_W-1:0]     acc_time,
  input  logic [VALUE_BITS-1:0] acc_value,
  output q_head_t               head,
  output logic [TIME_W-1:0]     head_time,
  output logic [VALUE_BITS-1:0] head_value,
  input  logic                  pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t                  q_cmd_r   [QUEUE_DEPTH];
  logic [TIME_W-1:0]     q_time_r  [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] q_value_r [QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]           fill_r, fill_nxt;
  logic                  push;
  logic                  do_pop;

  assign acc_ready = (fill_r != (PW+1)'(QUEUE_DEPTH));
  assign push      = acc_valid && acc_ready && (acc_cmd != CMD_IGNORE);
  assign do_pop    = pop && (fill_r != '0);

  assign head.valid = (fill_r != '0);
  assign head.cmd   = q_cmd_r[rd_ptr_r];
  assign head_time  = q_time_r[rd_ptr_r];
  assign head_value = q_value_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (PW+1)'(push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r]   <= acc_cmd;
      q_time_r[wr_ptr_r]  <= acc_time;
      q_value_r[wr_ptr_r] <= acc_value;
    end
  end

endmodule

// File: hw/rtl/pdd_engine.sv
// Back end: sample store, window scan, bucket min/max search and point emission.
module pdd_engine import pdd_pkg::*; #(
  parameter int SAMPLE_DEPTH = 4096,
  parameter int VALUE_BITS   = 16,
  localparam int CW = $clog2(SAMPLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_head_t               head,
  input  logic [TIME_W-1:0]     head_time,
  input  logic [VALUE_BITS-1:0] head_value,
  output logic                  pop,
  input  logic                  cfg_we,
  input  reg_idx_t              cfg_idx,
  input  logic [TIME_W-1:0]     cfg_wdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [TIME_W-1:0]     res_time,
  output logic [VALUE_BITS-1:0] res_value,
  output logic [CW-1:0]         res_visible,
  output logic                  res_last,
  output logic                  res_none,
  output logic                  res_ovf
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int XW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [TIME_W-1:0]     mem_time [SAMPLE_DEPTH];
  logic [VALUE_BITS-1:0] mem_val  [SAMPLE_DEPTH];
  logic [TIME_W-1:0]     rd_time_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [AW-1:0]         mem_addr;
  logic                  mem_we;

  eng_state_t state_r, state_nxt;
  phase_t     phase_r;

  logic [CW-1:0]      count_r;
  logic               ovf_r;
  logic [TIME_W-1:0]  wstart_r, wend_r;
  logic [LIMIT_W-1:0] limit_r;

  logic [CW-1:0] scan_i_r, b_r, e_r, vis_r, len_r, btot_r, emit_r;
  logic          fb_r, fe_r;
  logic [AW-1:0] base_r;
  logic [CW-1:0] bnum_r, bb_r, bq_r, bi_r, lo_i_r, hi_i_r;
  logic [XW:0]   brem_r;
  logic signed [VALUE_BITS-1:0] minv_r, maxv_r;
  logic [CW-1:0] slot_r [4];
  logic [2:0]    scnt_r, cur_r;
  logic          bemit_r, elast_r, emore_r;

  logic [TIME_W-1:0]     out_time_r;
  logic [VALUE_BITS-1:0] out_val_r;
  logic [CW-1:0]         out_vis_r;
  logic                  out_valid_r, out_last_r, out_none_r, out_ovf_r;

  // combinational helpers
  logic [TIME_W-1:0] win_lo, win_hi;
  logic              hit_b, hit_e, idle_cmd, out_free;
  logic [CW-1:0]     bg, eg, glen, vis_calc;
  logic [XW-1:0]     lq, btot_calc;
  logic [CW-1:0]     idx, emit_inc;
  logic [2:0]        cur_inc;
  logic              last_calc;
  logic [CW-1:0]     rep [4];
  logic [CW-1:0]     sl  [4];
  logic [2:0]        scnt;
  logic signed [VALUE_BITS-1:0] sv;

  assign win_lo   = (wend_r < wstart_r) ? wend_r : wstart_r;
  assign win_hi   = (wend_r < wstart_r) ? wstart_r : wend_r;
  assign hit_b    = !fb_r && (rd_time_r >= win_lo);
  assign hit_e    = !fe_r && (rd_time_r > win_hi);
  assign idle_cmd = (state_r == S_IDLE) && head.valid;
  assign out_free = !out_valid_r || res_ready;
  assign sv       = $signed(rd_val_r);

  assign vis_calc = (b_r < e_r) ? e_r - b_r : '0;
  assign bg       = (b_r != '0) ? b_r - 1'b1 : b_r;
  assign eg       = (e_r < count_r) ? e_r + 1'b1 : e_r;
  assign glen     = eg - bg;

  always_comb begin
    lq = XW'(limit_r) >> BUCKET_SHIFT;
    if (lq == '0) lq = XW'(1);
    btot_calc = (lq > XW'(glen)) ? XW'(glen) : lq;
  end

  always_comb begin
    emit_inc = emit_r + 1'b1;
    cur_inc  = cur_r + 1'b1;
    if (phase_r == PH_BUCKET) begin
      idx       = slot_r[cur_r[1:0]];
      last_calc = (XW'(emit_inc) >= XW'(limit_r)) ||
                  ((cur_inc >= scnt_r) && (bnum_r + 1'b1 >= btot_r));
    end else begin
      idx       = emit_r;
      last_calc = (emit_inc >= len_r);
    end
  end

  // representatives are already ordered apart from min/max; merge and drop repeats
  always_comb begin
    rep[0] = bb_r;
    rep[1] = (lo_i_r < hi_i_r) ? lo_i_r : hi_i_r;
    rep[2] = (lo_i_r < hi_i_r) ? hi_i_r : lo_i_r;
    rep[3] = bq_r - 1'b1;
    for (int j = 0; j < 4; j++) sl[j] = rep[0];
    scnt = '0;
    for (int j = 0; j < 4; j++) begin
      if (scnt == '0 || sl[2'(scnt - 1'b1)] != rep[j]) begin
        sl[scnt[1:0]] = rep[j];
        scnt = scnt + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid && head.cmd == CMD_FETCH) begin
          if (phase_r == PH_IDLE && count_r != '0 && limit_r != '0)
            state_nxt = S_SCAN_RD;
          else
            state_nxt = S_EMIT;
        end
      end
      S_SCAN_RD:  state_nxt = (scan_i_r == count_r) ? S_BUILD : S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = ((fb_r || hit_b) && (fe_r || hit_e)) ? S_BUILD : S_SCAN_RD;
      S_BUILD: begin
        if (bg >= eg || XW'(glen) <= XW'(limit_r)) state_nxt = S_EMIT;
        else                                        state_nxt = S_BDIV;
      end
      S_BDIV:  state_nxt = (brem_r >= (XW+1)'(btot_r)) ? S_BDIV : S_BRD;
      S_BRD:   state_nxt = S_BCHK;
      S_BCHK:  state_nxt = (bi_r + 1'b1 == bq_r) ? S_BSLOT : S_BRD;
      S_BSLOT: state_nxt = bemit_r ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_free)
          state_nxt = (phase_r == PH_DIRECT || phase_r == PH_BUCKET) ? S_OUT : S_IDLE;
      end
      S_OUT:   state_nxt = emore_r ? S_BDIV : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    mem_addr = base_r + AW'(bi_r);
    unique case (state_r)
      S_IDLE: begin
        pop    = head.valid;
        mem_we = head.valid && head.cmd == CMD_LOAD &&
                 count_r != CW'(SAMPLE_DEPTH);
      end
      S_SCAN_RD: mem_addr = AW'(scan_i_r);
      S_EMIT:    mem_addr = base_r + AW'(idx);
      default:   mem_addr = base_r + AW'(bi_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_time[AW'(count_r)] <= head_time;
      mem_val[AW'(count_r)]  <= head_value;
    end
    rd_time_r <= mem_time[mem_addr];
    rd_val_r  <= mem_val[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      wstart_r    <= '0;
      wend_r      <= '1;
      limit_r     <= LIMIT_W'(1024);
      vis_r       <= '0;
      emit_r      <= '0;
      bnum_r      <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_idx != REG_NONE) begin
        phase_r <= PH_IDLE;
        unique case (cfg_idx)
          REG_WSTART: wstart_r <= cfg_wdata;
          REG_WEND:   wend_r   <= cfg_wdata;
          REG_LIMIT:  limit_r  <= cfg_wdata[LIMIT_W-1:0];
          default:    ;
        endcase
      end
      if (out_valid_r && res_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (idle_cmd) begin
            unique case (head.cmd)
              CMD_LOAD: begin
                phase_r <= PH_IDLE;
                if (mem_we) count_r <= count_r + 1'b1;
                else        ovf_r   <= 1'b1;
              end
              CMD_CLEAR: begin
                phase_r <= PH_IDLE;
                count_r <= '0;
                ovf_r   <= 1'b0;
              end
              CMD_FETCH: begin
                if (phase_r == PH_IDLE) begin
                  emit_r   <= '0;
                  vis_r    <= '0;
                  phase_r  <= PH_DRAINED;
                  scan_i_r <= '0;
                  fb_r     <= 1'b0;
                  fe_r     <= 1'b0;
                  b_r      <= count_r;
                  e_r      <= count_r;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN_CHK: begin
          scan_i_r <= scan_i_r + 1'b1;
          if (hit_b) begin fb_r <= 1'b1; b_r <= scan_i_r; end
          if (hit_e) begin fe_r <= 1'b1; e_r <= scan_i_r; end
        end
        S_BUILD: begin
          vis_r  <= vis_calc;
          base_r <= AW'(bg);
          len_r  <= glen;
          if (bg < eg) begin
            if (XW'(glen) <= XW'(limit_r)) begin
              phase_r <= PH_DIRECT;
            end else begin
              phase_r <= PH_BUCKET;
              btot_r  <= CW'(btot_calc);
              bnum_r  <= '0;
              bb_r    <= '0;
              bq_r    <= '0;
              brem_r  <= (XW+1)'(glen);
              bemit_r <= 1'b1;
            end
          end
        end
        S_BDIV: begin
          if (brem_r >= (XW+1)'(btot_r)) begin
            brem_r <= brem_r - (XW+1)'(btot_r);
            bq_r   <= bq_r + 1'b1;
          end else begin
            bi_r <= bb_r;
          end
        end
        S_BCHK: begin
          bi_r <= bi_r + 1'b1;
          if (bi_r == bb_r) begin
            lo_i_r <= bi_r; hi_i_r <= bi_r;
            minv_r <= sv;   maxv_r <= sv;
          end else begin
            if (sv < minv_r) begin lo_i_r <= bi_r; minv_r <= sv; end
            if (sv > maxv_r) begin hi_i_r <= bi_r; maxv_r <= sv; end
          end
        end
        S_BSLOT: begin
          for (int j = 0; j < 4; j++) slot_r[j] <= sl[j];
          scnt_r <= scnt;
          cur_r  <= '0;
        end
        S_EMIT: begin
          if (out_free) begin
            if (phase_r == PH_DIRECT || phase_r == PH_BUCKET) begin
              emit_r  <= emit_inc;
              cur_r   <= cur_inc;
              elast_r <= last_calc;
              emore_r <= (phase_r == PH_BUCKET) && !last_calc && (cur_inc >= scnt_r);
              if (last_calc) phase_r <= PH_DRAINED;
            end else begin
              out_valid_r <= 1'b1;
              out_time_r  <= '0;
              out_val_r   <= '0;
              out_last_r  <= 1'b0;
              out_none_r  <= 1'b1;
              out_vis_r   <= vis_r;
              out_ovf_r   <= ovf_r;
            end
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_time_r  <= rd_time_r;
          out_val_r   <= rd_val_r;
          out_last_r  <= elast_r;
          out_none_r  <= 1'b0;
          out_vis_r   <= vis_r;
          out_ovf_r   <= ovf_r;
          if (emore_r) begin
            bnum_r  <= bnum_r + 1'b1;
            bb_r    <= bq_r;
            brem_r  <= brem_r + (XW+1)'(len_r);
            bemit_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // whole result word is held in registers while it waits
  assign res_valid   = out_valid_r;
  assign res_time    = out_time_r;
  assign res_value   = out_val_r;
  assign res_visible = out_vis_r;
  assign res_last    = out_last_r;
  assign res_none    = out_none_r;
  assign res_ovf     = out_ovf_r;

endmodule
